@@ rtl/fsnf_pkg.sv @@
// Shared constants, types and helper functions of the flow sketch block.
`default_nettype none

package fsnf_pkg;

	localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
	localparam int MIX_SHIFT = 33;

	localparam logic [63:0] ROW_SEED [4] = '{
		64'h9e3779b185ebca87, 64'hc2b2ae3d27d4eb4f,
		64'h165667b19e3779f9, 64'hd6e8feb86659fd93
	};

	localparam logic [63:0] BIT_SEED [8] = '{
		64'h27d4eb2f165667c5, 64'h94d049bb133111eb, 64'hbf58476d1ce4e5b9,
		64'h94d049bb133111eb ^ 64'h9e3779b185ebca87,
		64'hd6e8feb86659fd93, 64'ha5b85c5e198ed849,
		64'h165667b19e3779f9 ^ 64'hc2b2ae3d27d4eb4f,
		64'hff51afd7ed558ccd
	};

	// Index reduction folds the 64-bit hash in 16-bit digits, top digit first.
	localparam int MOD_BITS_PER_STEP = 16;
	localparam int MOD_STEPS = 64 / MOD_BITS_PER_STEP;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	typedef enum logic [3:0] {
		F_IDLE,
		F_LOAD,
		F_MUL0,
		F_MUL1,
		F_MUL2,
		F_MIX,
		F_MOD,
		F_FIX,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_WRITE,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [63:0] mix_xs(input logic [63:0] v);
		return v ^ (v >> MIX_SHIFT);
	endfunction

	// Width of one stored index: enough for the larger of the two row sizes.
	function automatic int mod_w(input int cols, input int bits);
		int a;
		int b;
		a = $clog2(cols);
		b = $clog2(bits);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/fsnf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fsnf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/fsnf_front.sv @@
// Front end: accepts packets, runs the seeded mixes and reduces them to row indexes.
`default_nettype none

module fsnf_front import fsnf_pkg::*; #(
	parameter int ROWS   = 4,
	parameter int COLS   = 1024,
	parameter int HASHES = 8,
	parameter int BITS   = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] flow_key,
	input  wire logic [31:0] weight,
	input  wire logic        clear_busy,
	input  queue_stat_t      qstat,
	output logic             push,
	output logic [32+(ROWS+HASHES)*mod_w(COLS, BITS)-1:0] push_data
);

	localparam int NH      = ROWS + HASHES;
	localparam int J_W     = $clog2(NH);
	localparam int MOD_W   = mod_w(COLS, BITS);
	localparam int ENTRY_W = 32 + NH * MOD_W;
	localparam logic [MOD_W:0] COLS_M = COLS[MOD_W:0];
	localparam logic [MOD_W:0] BITS_M = BITS[MOD_W:0];
	localparam logic [31:0] COLS_RECIP = 32'((64'd1 << 32) / 64'(COLS));
	localparam logic [31:0] BITS_RECIP = 32'((64'd1 << 32) / 64'(BITS));

	front_state_t         state_q, state_d;
	logic [J_W-1:0]       j_q;
	logic                 pass_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [63:0]          key_q;
	logic [31:0]          weight_q;
	logic [63:0]          v_q;
	logic [63:0]          acc_q;
	logic [MOD_W-1:0]     rem_q;
	logic [MOD_W:0]       quo_q;
	logic [MOD_W-1:0]     idx_q [NH];

	logic                 accept;
	logic                 mod_last;
	logic                 hash_last;
	logic [3:0]           j4;
	logic                 is_row;
	logic [63:0]          seed;
	logic [MOD_W:0]       modulus;
	logic [31:0]          recip;
	logic [31:0]          mod_x;
	logic [63:0]          mul_c;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          prod;
	logic [MOD_W:0]       quo_m;
	logic [MOD_W:0]       diff;
	logic [MOD_W-1:0]     rem_n;

	assign accept    = in_valid && !in_stall;
	assign mod_last  = cnt_q == MOD_CNT_W'(MOD_STEPS - 1);
	assign hash_last = j_q == J_W'(NH - 1);

	assign j4      = 4'(j_q);
	assign is_row  = j4 < 4'(ROWS);
	assign seed    = is_row ? ROW_SEED[j4[1:0]] : BIT_SEED[3'(j4 - 4'(ROWS))];
	assign modulus = is_row ? COLS_M : BITS_M;
	assign recip   = is_row ? COLS_RECIP : BITS_RECIP;
	assign mul_c   = pass_q ? MIX_MUL_B : MIX_MUL_A;
	assign prod    = mul_a * mul_b;
	// Running remainder followed by the next hash digit.
	assign mod_x   = {MOD_BITS_PER_STEP'(rem_q), v_q[63 -: MOD_BITS_PER_STEP]};

	// Quotient estimate is low by at most one, so one conditional subtract finishes.
	always_comb begin
		quo_m = quo_q * modulus;
		diff  = mod_x[MOD_W:0] - quo_m;
		if (diff >= modulus) begin
			diff = diff - modulus;
		end
		rem_n = diff[MOD_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_LOAD;
				end
			end
			F_LOAD: state_d = F_MUL0;
			F_MUL0: state_d = F_MUL1;
			F_MUL1: state_d = F_MUL2;
			F_MUL2: state_d = F_MIX;
			F_MIX:  state_d = pass_q ? F_MOD : F_MUL0;
			F_MOD:  state_d = F_FIX;
			F_FIX: begin
				if (mod_last) begin
					state_d = hash_last ? F_PUSH : F_LOAD;
				end else begin
					state_d = F_MOD;
				end
			end
			F_PUSH: begin
				if (!qstat.full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != F_IDLE) || clear_busy;
		push     = (state_q == F_PUSH) && !qstat.full;
		mul_a    = v_q[31:0];
		mul_b    = mul_c[31:0];
		unique case (state_q)
			F_MUL1: begin
				mul_b = mul_c[63:32];
			end
			F_MUL2: begin
				mul_a = v_q[63:32];
			end
			F_MOD: begin
				mul_a = mod_x;
				mul_b = recip;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			j_q     <= '0;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				F_IDLE: begin
					j_q <= '0;
				end
				F_LOAD: begin
					pass_q <= 1'b0;
				end
				F_MIX: begin
					pass_q <= 1'b1;
					cnt_q  <= '0;
				end
				F_FIX: begin
					cnt_q <= cnt_q + 1'b1;
					if (mod_last && !hash_last) begin
						j_q <= j_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					key_q    <= flow_key;
					weight_q <= weight;
				end
			end
			F_LOAD: begin
				v_q <= mix_xs(key_q ^ seed);
			end
			F_MUL0: begin
				acc_q <= prod;
			end
			F_MUL1, F_MUL2: begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
			F_MIX: begin
				v_q   <= mix_xs(acc_q);
				rem_q <= '0;
			end
			F_MOD: begin
				quo_q <= prod[32 +: MOD_W + 1];
			end
			F_FIX: begin
				v_q   <= v_q << MOD_BITS_PER_STEP;
				rem_q <= rem_n;
				if (mod_last) begin
					idx_q[j_q] <= rem_n;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push_data = '0;
		push_data[ENTRY_W-1 -: 32] = weight_q;
		for (int i = 0; i < NH; i++) begin
			push_data[i*MOD_W +: MOD_W] = idx_q[i];
		end
	end

endmodule

`default_nettype wire

@@ rtl/fsnf_queue.sv @@
// Short queue of hashed packets between the front end and the update engine.
`default_nettype none

module fsnf_queue import fsnf_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output queue_stat_t           stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.empty = count_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/fsnf_back.sv @@
// Update engine: clears the stores, then does counter and filter read-modify-writes.
`default_nettype none

module fsnf_back import fsnf_pkg::*; #(
	parameter int ROWS   = 4,
	parameter int COLS   = 1024,
	parameter int HASHES = 8,
	parameter int BITS   = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  queue_stat_t      qstat,
	output logic             pop,
	input  wire logic [32+(ROWS+HASHES)*mod_w(COLS, BITS)-1:0] pop_data,
	output logic             clear_busy,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             already_seen
);

	localparam int NH       = ROWS + HASHES;
	localparam int COL_W    = $clog2(COLS);
	localparam int BIT_W    = $clog2(BITS);
	localparam int MOD_W    = mod_w(COLS, BITS);
	localparam int ENTRY_W  = 32 + NH * MOD_W;
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int HSH_W    = (HASHES > 1) ? $clog2(HASHES) : 1;
	localparam int SK_DEPTH = ROWS * (2 ** COL_W);
	localparam int BL_DEPTH = HASHES * (2 ** BIT_W);
	localparam int SK_AW    = $clog2(SK_DEPTH);
	localparam int BL_AW    = $clog2(BL_DEPTH);
	localparam int CLR_LEN  = (SK_DEPTH > BL_DEPTH) ? SK_DEPTH : BL_DEPTH;
	localparam int CLR_W    = $clog2(CLR_LEN);
	localparam int NOPS     = (ROWS > HASHES) ? ROWS : HASHES;
	localparam int K_W      = (NOPS > 1) ? $clog2(NOPS) : 1;

	back_state_t        state_q, state_d;
	logic [CLR_W-1:0]   clr_q;
	logic [K_W-1:0]     k_q;
	logic [ENTRY_W-1:0] entry_q;
	logic               all_set_q;
	logic               out_valid_q;
	logic               already_seen_q;

	logic               out_free;
	logic               k_last;
	logic               clr_last;
	logic               sk_op;
	logic               bl_op;
	logic [K_W-1:0]     sk_slot;
	logic [K_W-1:0]     bl_slot;
	logic [COL_W-1:0]   sk_col;
	logic [BIT_W-1:0]   bl_pos;
	logic [31:0]        weight_q;
	logic [SK_AW-1:0]   sk_addr;
	logic [BL_AW-1:0]   bl_addr;

	logic               sk_we;
	logic [SK_AW-1:0]   sk_waddr;
	logic [31:0]        sk_wdata;
	logic [31:0]        sk_rdata;
	logic               bl_we;
	logic [BL_AW-1:0]   bl_waddr;
	logic [0:0]         bl_wdata;
	logic [0:0]         bl_rdata;

	assign out_free = !out_valid_q || !out_stall;
	assign k_last   = k_q == K_W'(NOPS - 1);
	assign clr_last = clr_q == CLR_W'(CLR_LEN - 1);
	assign sk_op    = 32'(k_q) < ROWS;
	assign bl_op    = 32'(k_q) < HASHES;
	// Park the slot on zero for rows this op does not touch.
	assign sk_slot  = sk_op ? k_q : '0;
	assign bl_slot  = bl_op ? k_q : '0;
	assign sk_col   = entry_q[32'(sk_slot)*MOD_W +: COL_W];
	assign bl_pos   = entry_q[(ROWS + 32'(bl_slot))*MOD_W +: BIT_W];
	assign weight_q = entry_q[ENTRY_W-1 -: 32];
	assign sk_addr  = SK_AW'({ROW_W'(sk_slot), sk_col});
	assign bl_addr  = BL_AW'({HSH_W'(bl_slot), bl_pos});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: begin
				if (clr_last) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!qstat.empty) begin
					state_d = B_READ;
				end
			end
			B_READ:  state_d = B_WRITE;
			B_WRITE: state_d = k_last ? B_OUT : B_READ;
			B_OUT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_CLEAR;
		endcase
	end

	always_comb begin
		clear_busy = state_q == B_CLEAR;
		pop        = (state_q == B_IDLE) && !qstat.empty;
		sk_we      = 1'b0;
		sk_waddr   = sk_addr;
		sk_wdata   = sk_rdata + weight_q;
		bl_we      = 1'b0;
		bl_waddr   = bl_addr;
		bl_wdata   = 1'b1;
		unique case (state_q)
			B_CLEAR: begin
				sk_we    = 32'(clr_q) < SK_DEPTH;
				sk_waddr = clr_q[SK_AW-1:0];
				sk_wdata = '0;
				bl_we    = 32'(clr_q) < BL_DEPTH;
				bl_waddr = clr_q[BL_AW-1:0];
				bl_wdata = 1'b0;
			end
			B_WRITE: begin
				sk_we = sk_op;
				bl_we = bl_op;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				B_IDLE: begin
					k_q <= '0;
				end
				B_WRITE: begin
					if (!k_last) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if ((state_q == B_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q   <= pop_data;
			all_set_q <= 1'b1;
		end
		if ((state_q == B_WRITE) && bl_op && !bl_rdata[0]) begin
			all_set_q <= 1'b0;
		end
		if ((state_q == B_OUT) && out_free) begin
			already_seen_q <= all_set_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign already_seen = already_seen_q;

	fsnf_ram #(
		.WIDTH(32),
		.DEPTH(SK_DEPTH)
	) u_sketch_ram (
		.clk  (clk),
		.we   (sk_we),
		.waddr(sk_waddr),
		.wdata(sk_wdata),
		.raddr(sk_addr),
		.rdata(sk_rdata)
	);

	fsnf_ram #(
		.WIDTH(1),
		.DEPTH(BL_DEPTH)
	) u_bloom_ram (
		.clk  (clk),
		.we   (bl_we),
		.waddr(bl_waddr),
		.wdata(bl_wdata),
		.raddr(bl_addr),
		.rdata(bl_rdata)
	);

endmodule

`default_nettype wire

@@ rtl/flow_sketch_and_new_flow_check.sv @@
// The front end takes one packet at a time; its shared 32x32 multiplier does
// two mix multiplies, then one reciprocal step per 16-bit digit, for each hash.
// The update engine does a read step and then a write step per row on its RAM ports.
// Reset: a clearing pass writes zero to every address of both stores; in_stall is high meanwhile.
`default_nettype none

module flow_sketch_and_new_flow_check import fsnf_pkg::*; #(
	parameter int SKETCH_ROWS    = 4,
	parameter int SKETCH_COLUMNS = 1024,
	parameter int BLOOM_HASHES   = 8,
	parameter int BLOOM_ROW_BITS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] flow_key,
	input  wire logic [31:0] weight,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             already_seen
);

	localparam int ENTRY_W = 32 + (SKETCH_ROWS + BLOOM_HASHES)
		* mod_w(SKETCH_COLUMNS, BLOOM_ROW_BITS);

	queue_stat_t        qstat;
	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic [ENTRY_W-1:0] pop_data;
	logic               clear_busy;

	fsnf_front #(
		.ROWS  (SKETCH_ROWS),
		.COLS  (SKETCH_COLUMNS),
		.HASHES(BLOOM_HASHES),
		.BITS  (BLOOM_ROW_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.flow_key  (flow_key),
		.weight    (weight),
		.clear_busy(clear_busy),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	fsnf_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (qstat)
	);

	fsnf_back #(
		.ROWS  (SKETCH_ROWS),
		.COLS  (SKETCH_COLUMNS),
		.HASHES(BLOOM_HASHES),
		.BITS  (BLOOM_ROW_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop         (pop),
		.pop_data    (pop_data),
		.clear_busy  (clear_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.already_seen(already_seen)
	);

endmodule

`default_nettype wire

@@ rtl/fsnf_checker.sv @@
// Port-level checks of the flow sketch block and their bind to the top level.
`default_nettype none

module fsnf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [63:0] flow_key,
	input wire logic [31:0] weight,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        already_seen
);

	// Front register, two queue slots, update engine and output register.
	localparam logic [3:0] MAX_IN_FLIGHT = 4'd5;

	logic [3:0] in_flight_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else if (in_beat && !out_beat) begin
			in_flight_q <= in_flight_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			in_flight_q <= in_flight_q - 1'b1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(flow_key) && $stable(weight))
		else $error("input beat changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(already_seen))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input taken again right after a beat");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_flight_q != 4'd0)
		else $error("result offered with no packet in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= MAX_IN_FLIGHT)
		else $error("more packets in flight than the block can hold");

endmodule

bind flow_sketch_and_new_flow_check fsnf_checker u_fsnf_checker (.*);

`default_nettype wire

@@ test/flow_sketch_and_new_flow_check_tb.sv @@
// Self-checking bench for the flow sketch block: directed and random packets, new-flow flag checked.
module flow_sketch_and_new_flow_check_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SKETCH_ROWS    = 4;
	localparam int SKETCH_COLUMNS = 1024;
	localparam int BLOOM_HASHES   = 8;
	localparam int BLOOM_ROW_BITS = 4096;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 600;
	localparam int PHASE_ITEMS  = 208;
	localparam int MAX_REPORTS  = 10;

	localparam int SEND_IDLE [4]  = '{0, 81, 0, 12};
	localparam int RECV_STALL [4] = '{0, 0, 81, 12};

	localparam logic [63:0] MUL_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MUL_B = 64'hc4ceb9fe1a85ec53;

	localparam logic [63:0] COUNT_SEED [4] = '{
		64'h9e3779b185ebca87, 64'hc2b2ae3d27d4eb4f,
		64'h165667b19e3779f9, 64'hd6e8feb86659fd93
	};

	localparam logic [63:0] BLOOM_SEED [8] = '{
		64'h27d4eb2f165667c5, 64'h94d049bb133111eb, 64'hbf58476d1ce4e5b9,
		64'h94d049bb133111eb ^ 64'h9e3779b185ebca87,
		64'hd6e8feb86659fd93, 64'ha5b85c5e198ed849,
		64'h165667b19e3779f9 ^ 64'hc2b2ae3d27d4eb4f,
		64'hff51afd7ed558ccd
	};

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] w;
	} packet_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] flow_key = '0;
	logic [31:0] weight = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        already_seen;

	// Shadow copies of the two stores; both start cleared.
	bit [31:0] flow_count [SKETCH_ROWS][SKETCH_COLUMNS];
	bit        bloom_map [BLOOM_HASHES][BLOOM_ROW_BITS];

	packet_t     feed [$];
	bit          seen_forecast [$];
	logic [63:0] key_pool [$];

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   errors = 0;
	int   checked = 0;
	int   accepted = 0;
	int   repeat_hits = 0;
	int   cycle_count = 0;
	logic in_taken;
	bit   predicted_seen;

	flow_sketch_and_new_flow_check #(
		.SKETCH_ROWS(SKETCH_ROWS),
		.SKETCH_COLUMNS(SKETCH_COLUMNS),
		.BLOOM_HASHES(BLOOM_HASHES),
		.BLOOM_ROW_BITS(BLOOM_ROW_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.flow_key(flow_key),
		.weight(weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.already_seen(already_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] mix64(input logic [63:0] v);
		logic [63:0] x;
		x = v ^ (v >> 33);
		x = x * MUL_A;
		x = x ^ (x >> 33);
		x = x * MUL_B;
		return x ^ (x >> 33);
	endfunction

	// Add the weight to the flow's counter in every row, then probe and set the Bloom bits.
	function automatic bit bloom_probe_and_count(input logic [63:0] key, input logic [31:0] w);
		bit          all_set;
		logic [63:0] h;
		int          idx;
		all_set = 1'b1;
		for (int r = 0; r < SKETCH_ROWS; r++) begin
			h = mix64(key ^ COUNT_SEED[r]);
			idx = int'(h % 64'(SKETCH_COLUMNS));
			flow_count[r][idx] = flow_count[r][idx] + w;
		end
		for (int b = 0; b < BLOOM_HASHES; b++) begin
			h = mix64(key ^ BLOOM_SEED[b]);
			idx = int'(h % 64'(BLOOM_ROW_BITS));
			if (!bloom_map[b][idx])
				all_set = 1'b0;
			bloom_map[b][idx] = 1'b1;
		end
		return all_set;
	endfunction

	function automatic void queue_packet(input logic [63:0] key, input logic [31:0] w);
		packet_t pkt;
		pkt.key = key;
		pkt.w = w;
		feed.push_back(pkt);
		key_pool.push_back(key);
	endfunction

	function automatic void flag_error(input string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("error at cycle %0d: %s", cycle_count, what);
	endfunction

	// Drive the next beat once the current one is taken; hold it while stalled.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				flow_key <= feed[0].key;
				weight <= feed[0].w;
				void'(feed.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				seen_forecast.push_back(bloom_probe_and_count(flow_key, weight));
				accepted++;
			end
			if (out_valid && !out_stall) begin
				checked++;
				if (seen_forecast.size() == 0) begin
					flag_error($sformatf("result with nothing pending, already_seen %0b",
						already_seen));
				end else begin
					predicted_seen = seen_forecast.pop_front();
					if (predicted_seen)
						repeat_hits++;
					if (already_seen !== predicted_seen)
						flag_error($sformatf("result %0d: already_seen expected %0b got %0b",
							checked, predicted_seen, already_seen));
				end
			end
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results pending", cycle_count,
					seen_forecast.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int          sel;
		logic [63:0] k;
		logic [31:0] w;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			if (p == 0) begin
				queue_packet(64'h0, 32'h0);
				queue_packet(64'h0, 32'hffffffff);
				queue_packet('1, 32'hffffffff);
				// counter wraps past 2^32
				queue_packet('1, 32'h1);
				// key equal to a seed zeroes the hash input of that row
				for (int r = 0; r < SKETCH_ROWS; r++)
					queue_packet(COUNT_SEED[r], 32'h55555555);
				for (int b = 0; b < BLOOM_HASHES; b++)
					queue_packet(BLOOM_SEED[b], b[0] ? 32'haaaaaaaa : 32'h0);
				queue_packet(64'h5555555555555555, 32'haaaaaaaa);
				queue_packet(64'haaaaaaaaaaaaaaaa, 32'h55555555);
				queue_packet(64'h8000000000000000, 32'h80000000);
				queue_packet(64'h1, 32'h1);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				sel = $urandom_range(19);
				if (sel < 9)
					k = {$urandom, $urandom};
				else if (sel < 17)
					k = key_pool[$urandom_range(key_pool.size() - 1)];
				else if (sel < 19)
					k = key_pool[$urandom_range(key_pool.size() - 1)]
						^ (64'h1 << $urandom_range(63));
				else
					k = 64'($urandom_range(255));
				case ($urandom_range(3))
					0: w = $urandom;
					1: w = 32'h0;
					2: w = 32'hffffffff;
					default: w = 32'($urandom_range(15));
				endcase
				queue_packet(k, w);
			end
			while (feed.size() != 0 || in_valid || seen_forecast.size() != 0)
				@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d packets sent over four flow-control phases, %0d results checked",
			accepted, checked);
		$display("%0d flows reported as already seen, %0d mismatches", repeat_hits, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
